@@ design/distinct_window_marker_detector_top_macros.svh @@
// Assertion macros for the distinct window marker detector.
`ifndef DISTINCT_WINDOW_MARKER_DETECTOR_TOP_MACROS_SVH
`define DISTINCT_WINDOW_MARKER_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DWMD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dwmd assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DWMD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dwmd assertion failed");

`endif

@@ design/dwmd_pkg.sv @@
// Shared constants and types of the distinct window marker detector.
`timescale 1ns / 1ps

package dwmd_pkg;

	localparam int unsigned SYM_W      = 8;
	localparam int unsigned SYM_DEPTH  = 2 ** SYM_W;
	localparam int unsigned COUNT_W    = 16;
	localparam int unsigned CFG_W      = 5;
	localparam int unsigned MAX_WINDOW = 16;
	localparam int unsigned MIN_WINDOW = 2;
	localparam int unsigned STAMP_W    = 64;
	// distance values span 0..MAX_WINDOW, plus one code for "far"
	localparam int unsigned DIST_W     = $clog2(MAX_WINDOW + 2);

	localparam logic [CFG_W-1:0]   WINDOW_RESET = CFG_W'(4);
	localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
	localparam logic [DIST_W-1:0]  DIST_CAP     = DIST_W'(MAX_WINDOW);
	localparam logic [DIST_W-1:0]  DIST_FAR     = DIST_W'(MAX_WINDOW + 1);

	typedef struct packed {
		logic               en;
		logic [SYM_W-1:0]   addr;
		logic [STAMP_W-1:0] stamp;
	} tbl_wr_t;

	typedef struct packed {
		logic               hit;
		logic [STAMP_W-1:0] stamp;
	} tbl_rsp_t;

endpackage

@@ design/dwmd_stamp_table.sv @@
// Last-seen stamp table: one entry per symbol value, with write forwarding.
`timescale 1ns / 1ps

module dwmd_stamp_table (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    rd_en,
	input  logic [dwmd_pkg::SYM_W-1:0]              rd_addr,
	input  dwmd_pkg::tbl_wr_t                       wr,
	output dwmd_pkg::tbl_rsp_t                      rsp
);

	logic [dwmd_pkg::STAMP_W-1:0] mem [dwmd_pkg::SYM_DEPTH];
	logic [dwmd_pkg::SYM_DEPTH-1:0] seen_q;
	logic [dwmd_pkg::STAMP_W-1:0] rd_data_q;
	logic [dwmd_pkg::STAMP_W-1:0] fwd_stamp_q;
	logic                         fwd_q;
	logic                         hit_q;
	logic                         fwd;

	assign fwd = wr.en && (wr.addr == rd_addr);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.stamp;
		end
		if (rd_en) begin
			rd_data_q   <= mem[rd_addr];
			fwd_stamp_q <= wr.stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			hit_q  <= 1'b0;
			fwd_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				seen_q[wr.addr] <= 1'b1;
			end
			// a write to the entry being read lands this edge: take its stamp
			if (rd_en) begin
				fwd_q <= fwd;
				hit_q <= seen_q[rd_addr] || fwd;
			end
		end
	end

	assign rsp.hit   = hit_q;
	assign rsp.stamp = fwd_q ? fwd_stamp_q : rd_data_q;

endmodule

@@ design/distinct_window_marker_detector_top.sv @@
// Accepted requests are registered in stage s1, then in the output registers.
// Throughput: one symbol per cycle unless out_stall holds the output, set by the
// single read and write port of the 256-entry stamp table, read on accept, written from s1.
// Reset: count, distance, found flag and stamp counter clear, window_size
// returns to 4, and the table's seen bits clear at once; no clearing pass.
`timescale 1ns / 1ps
`include "distinct_window_marker_detector_top_macros.svh"

module distinct_window_marker_detector_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dwmd_pkg::CFG_W-1:0]          window_size,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dwmd_pkg::SYM_W-1:0]          symbol,
	input  logic                                line_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dwmd_pkg::COUNT_W-1:0]        position,
	output logic                                marker_here,
	output logic                                marker_found
);

	logic [dwmd_pkg::CFG_W-1:0]   window_size_q;
	logic [dwmd_pkg::DIST_W-1:0]  win_eff;

	logic                         s1_valid_s1;
	logic [dwmd_pkg::SYM_W-1:0]   sym_s1;
	logic                         line_end_s1;

	logic [dwmd_pkg::STAMP_W-1:0] stamp_q;
	logic [dwmd_pkg::DIST_W-1:0]  dist_q;
	logic [dwmd_pkg::COUNT_W-1:0] count_q;
	logic                         found_q;

	logic                         out_valid_q;
	logic [dwmd_pkg::COUNT_W-1:0] position_q;
	logic                         marker_here_q;
	logic                         marker_found_q;

	logic                         out_free;
	logic                         s1_adv;
	logic                         accept;

	dwmd_pkg::tbl_wr_t            tbl_wr;
	dwmd_pkg::tbl_rsp_t           tbl_rsp;

	logic [dwmd_pkg::STAMP_W-1:0] gap;
	logic [dwmd_pkg::DIST_W-1:0]  gap_dist;
	logic [dwmd_pkg::DIST_W-1:0]  dist_inc;
	logic [dwmd_pkg::DIST_W-1:0]  dist_new;
	logic [dwmd_pkg::COUNT_W-1:0] count_new;
	logic                         here_new;

	// handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_adv    = s1_valid_s1 && out_free;
	assign in_stall  = s1_valid_s1 && !out_free;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// clamp the configured size into the supported range
	always_comb begin
		if (window_size_q < dwmd_pkg::MIN_WINDOW) begin
			win_eff = dwmd_pkg::DIST_W'(dwmd_pkg::MIN_WINDOW);
		end else if (window_size_q > dwmd_pkg::MAX_WINDOW) begin
			win_eff = dwmd_pkg::DIST_W'(dwmd_pkg::MAX_WINDOW);
		end else begin
			win_eff = dwmd_pkg::DIST_W'(window_size_q);
		end
	end

	assign tbl_wr.en    = s1_adv;
	assign tbl_wr.addr  = sym_s1;
	assign tbl_wr.stamp = stamp_q;

	dwmd_stamp_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (symbol),
		.wr      (tbl_wr),
		.rsp     (tbl_rsp)
	);

	// distance back to the previous copy of this symbol, saturated past MAX_WINDOW;
	// a copy from an earlier line is always at least dist_q + 1 back
	assign gap = stamp_q - tbl_rsp.stamp;

	always_comb begin
		if (!tbl_rsp.hit || (gap > dwmd_pkg::STAMP_W'(dwmd_pkg::MAX_WINDOW))) begin
			gap_dist = dwmd_pkg::DIST_FAR;
		end else begin
			gap_dist = dwmd_pkg::DIST_W'(gap);
		end
		dist_inc = (dist_q == dwmd_pkg::DIST_CAP) ? dwmd_pkg::DIST_CAP
			: dist_q + dwmd_pkg::DIST_W'(1);
		dist_new  = (gap_dist < dist_inc) ? gap_dist : dist_inc;
		count_new = (count_q == dwmd_pkg::COUNT_MAX) ? count_q
			: count_q + dwmd_pkg::COUNT_W'(1);
		here_new  = !found_q && (dist_new >= win_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= dwmd_pkg::WINDOW_RESET;
			s1_valid_s1   <= 1'b0;
			out_valid_q   <= 1'b0;
			stamp_q       <= '0;
			dist_q        <= '0;
			count_q       <= '0;
			found_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				window_size_q <= window_size;
			end
			if (accept) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				stamp_q <= stamp_q + dwmd_pkg::STAMP_W'(1);
				// restart the line after its last symbol
				if (line_end_s1) begin
					dist_q  <= '0;
					count_q <= '0;
					found_q <= 1'b0;
				end else begin
					dist_q  <= dist_new;
					count_q <= count_new;
					found_q <= found_q || here_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_s1      <= symbol;
			line_end_s1 <= line_end;
		end
		if (s1_adv) begin
			position_q     <= count_new;
			marker_here_q  <= here_new;
			marker_found_q <= found_q || here_new;
		end
	end

	assign out_valid    = out_valid_q;
	assign position     = position_q;
	assign marker_here  = marker_here_q;
	assign marker_found = marker_found_q;

	`DWMD_ASSERT_IMP(a_here_sets_found, out_valid && marker_here, marker_found)
	`DWMD_ASSERT_IMP(a_here_needs_full_window, out_valid && marker_here,
		position >= dwmd_pkg::COUNT_W'(win_eff))
	`DWMD_ASSERT_NXT(a_one_marker_per_line, s1_adv && found_q && !line_end_s1, !marker_here)
	`DWMD_ASSERT_IMP(a_empty_stage_takes_request, !s1_valid_s1, !in_stall)

endmodule
